FILE: sv/tbpf_pkg.sv
// ----------------------------------------------------------------------------
// tbpf_pkg
// Shared types and constants of the tile background pixel fetch block.
// ----------------------------------------------------------------------------
package tbpf_pkg;

    localparam int RAM_ADDR_BITS = 14;
    localparam int RAM_DEPTH     = 1 << RAM_ADDR_BITS;

    // display modes
    localparam logic [3:0] MODE_PATCOL   = 4'd0;
    localparam logic [3:0] MODE_BITMAP   = 4'd2;
    localparam logic [3:0] MODE_TILE_8   = 4'd8;
    localparam logic [3:0] MODE_TILE_10  = 4'd10;
    localparam logic [3:0] MODE_TILE_11  = 4'd11;
    localparam logic [3:0] MODE_TILE_12  = 4'd12;
    localparam logic [3:0] MODE_TILE_14  = 4'd14;
    localparam logic [3:0] MODE_TILE_15  = 4'd15;

    // line and column limits
    localparam logic [8:0] LOCK_LINES    = 9'd16;
    localparam logic [7:0] LOCK_COLUMN   = 8'd191;
    localparam logic [8:0] WRAP_LINES    = 9'd224;
    localparam logic [8:0] BANK1_FIRST   = 9'd64;
    localparam logic [8:0] BANK1_LAST    = 9'd127;
    localparam logic [8:0] BANK2_FIRST   = 9'd128;
    localparam logic [8:0] BANK2_LAST    = 9'd191;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_DISPLAY_MODE = 3'd0,
        REG_NAME_BASE    = 3'd1,
        REG_PATTERN_BASE = 3'd2,
        REG_COLOR_BASE   = 3'd3,
        REG_SCROLL_X     = 3'd4,
        REG_SCROLL_Y     = 3'd5,
        REG_LOCK_TOP     = 3'd6,
        REG_LOCK_RIGHT   = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [3:0] display_mode;
        logic [3:0] name_table_base;
        logic [2:0] pattern_table_base;
        logic [7:0] color_table_base;
        logic [7:0] scroll_x;
        logic [7:0] scroll_y;
        logic       lock_top_rows;
        logic       lock_right_columns;
    } t_cfg;

    // job classes handed from front to back
    typedef enum logic [2:0] {
        K_WRITE  = 3'd0,
        K_BLANK  = 3'd1,
        K_PATCOL = 3'd2,
        K_BITMAP = 3'd3,
        K_TILE   = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind                    kind;
        logic [2:0]               px;        // column within tile row
        logic [2:0]               py;        // line within tile
        logic [RAM_ADDR_BITS-1:0] name_addr;
        logic [RAM_ADDR_BITS-1:0] p_hi;      // pattern address upper bits
        logic [RAM_ADDR_BITS-1:0] c_hi;      // color address upper bits
        logic [RAM_ADDR_BITS-1:0] wr_addr;
        logic [7:0]               wr_data;
    } t_job;

    // leftmost pixel is bit 7
    function automatic logic pick_bit(input logic [7:0] b, input logic [2:0] sel);
        return b[~sel];
    endfunction

endpackage

FILE: sv/tbpf_front.sv
// ----------------------------------------------------------------------------
// tbpf_front
// Classifies an incoming item by operation and mode, applies scroll, locks
// and line wrap, and builds the name and table base addresses of the job.
// ----------------------------------------------------------------------------
module tbpf_front import tbpf_pkg::*; (
    input  t_cfg                     i_cfg,
    input  logic                     i_operation,
    input  logic [7:0]               i_pixel_column,
    input  logic [8:0]               i_pixel_line,
    input  logic [RAM_ADDR_BITS-1:0] i_ram_address,
    input  logic [7:0]               i_ram_data,
    output t_job                     o_job
);

    logic                     tile_blank;
    logic [7:0]               col_s;
    logic [8:0]               line_s;
    logic [8:0]               line_192;
    logic [8:0]               line_big;
    logic                     in_bank1;
    logic                     in_bank2;
    logic [RAM_ADDR_BITS-1:0] bank;
    logic [RAM_ADDR_BITS-1:0] name_192;
    logic [RAM_ADDR_BITS-1:0] name_big;
    logic [RAM_ADDR_BITS-1:0] name_gfx;

    always_comb begin
        tile_blank = i_pixel_column < {5'd0, i_cfg.scroll_x[2:0]};
        col_s = (!i_cfg.lock_top_rows || i_pixel_line >= LOCK_LINES) ?
                i_pixel_column - i_cfg.scroll_x : i_pixel_column;
        line_s = (!i_cfg.lock_right_columns || col_s <= LOCK_COLUMN) ?
                 i_pixel_line + {1'b0, i_cfg.scroll_y} : i_pixel_line;
        line_192 = (line_s >= WRAP_LINES) ? line_s - WRAP_LINES : line_s;
        line_big = line_s + WRAP_LINES;
        name_192 = {i_cfg.name_table_base[3:1], line_192[7:3], col_s[7:3], 1'b0};
        name_big = {i_cfg.name_table_base[3:2], line_big[8:3], col_s[7:3], 1'b0};
        name_gfx = {i_cfg.name_table_base, i_pixel_line[7:3], i_pixel_column[7:3]};

        in_bank1 = i_pixel_line >= BANK1_FIRST && i_pixel_line <= BANK1_LAST;
        in_bank2 = i_pixel_line >= BANK2_FIRST && i_pixel_line <= BANK2_LAST;
        bank = {1'b0, in_bank2 & i_cfg.pattern_table_base[1],
                in_bank1 & i_cfg.pattern_table_base[0], 11'd0};

        o_job           = '0;
        o_job.kind      = K_BLANK;
        o_job.wr_addr   = i_ram_address;
        o_job.wr_data   = i_ram_data;
        o_job.px        = i_pixel_column[2:0];
        o_job.py        = i_pixel_line[2:0];
        o_job.name_addr = name_gfx;

        unique case (i_cfg.display_mode)
            MODE_PATCOL: begin
                o_job.kind = K_PATCOL;
                o_job.p_hi = {i_cfg.pattern_table_base, 11'd0};
                o_job.c_hi = {i_cfg.color_table_base, 6'd0};
            end
            MODE_BITMAP: begin
                o_job.kind = K_BITMAP;
                o_job.p_hi = bank | {i_cfg.pattern_table_base[2], 13'd0};
                o_job.c_hi = bank | {i_cfg.color_table_base[7], 13'd0};
            end
            MODE_TILE_8, MODE_TILE_10, MODE_TILE_12, MODE_TILE_15: begin
                o_job.kind      = tile_blank ? K_BLANK : K_TILE;
                o_job.px        = col_s[2:0];
                o_job.py        = line_192[2:0];
                o_job.name_addr = name_192;
            end
            MODE_TILE_11, MODE_TILE_14: begin
                o_job.kind      = tile_blank ? K_BLANK : K_TILE;
                o_job.px        = col_s[2:0];
                o_job.py        = line_big[2:0];
                o_job.name_addr = name_big;
            end
            default: o_job.kind = K_BLANK;
        endcase

        if (i_operation) begin
            o_job.kind = K_WRITE;
        end
    end

endmodule

FILE: sv/tbpf_queue.sv
// ----------------------------------------------------------------------------
// tbpf_queue
// Short job queue between the front classifier and the fetch sequencer.
// ----------------------------------------------------------------------------
module tbpf_queue import tbpf_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_head,
    output logic o_full,
    output logic o_empty
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [IW-1:0] r_wr;
    logic [IW-1:0] r_rd;
    logic [CW-1:0] r_cnt;

    assign o_full  = r_cnt == CW'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == IW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == IW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: sv/tbpf_back.sv
// ----------------------------------------------------------------------------
// tbpf_back
// Video RAM and the read sequencer that performs RAM writes and turns each
// pixel job into one pixel, with the result output register.
// ----------------------------------------------------------------------------
module tbpf_back import tbpf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_job       i_head,
    input  logic       i_empty,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [3:0] o_pixel_color,
    output logic       o_palette_select,
    output logic       o_priority_flag
);

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_G1   = 10'b00_0000_0010,
        S_G2   = 10'b00_0000_0100,
        S_G3   = 10'b00_0000_1000,
        S_T1   = 10'b00_0001_0000,
        S_T2   = 10'b00_0010_0000,
        S_T3   = 10'b00_0100_0000,
        S_T4   = 10'b00_1000_0000,
        S_T5   = 10'b01_0000_0000,
        S_T6   = 10'b10_0000_0000
    } t_state;

    logic [7:0]               mem [RAM_DEPTH];
    logic [7:0]               r_q;

    t_state                   r_state, n_state;
    t_job                     r_job;
    logic [7:0]               r_tile, n_tile;
    logic [7:0]               r_lo, n_lo;
    logic                     r_bit, n_bit;
    logic [2:0]               r_px, n_px;
    logic [2:0]               r_c, n_c;
    logic                     r_pal, n_pal;
    logic                     r_pri, n_pri;
    logic [RAM_ADDR_BITS-1:0] r_base, n_base;
    logic                     r_out_valid, n_out_valid;
    logic [3:0]               r_color, n_color;
    logic                     r_out_pal, n_out_pal;
    logic                     r_out_pri, n_out_pri;

    logic [RAM_ADDR_BITS-1:0] mem_addr;
    logic                     mem_we;
    logic                     mem_re;
    logic                     out_free;
    logic [15:0]              entry;
    logic [2:0]               py_f;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_tile      = r_tile;
        n_lo        = r_lo;
        n_bit       = r_bit;
        n_px        = r_px;
        n_c         = r_c;
        n_pal       = r_pal;
        n_pri       = r_pri;
        n_base      = r_base;
        n_out_valid = r_out_valid && !i_out_ready;
        n_color     = r_color;
        n_out_pal   = r_out_pal;
        n_out_pri   = r_out_pri;
        mem_addr    = i_head.wr_addr;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        o_pop       = 1'b0;
        entry       = {r_q, r_lo};
        py_f        = r_job.py ^ {3{entry[10]}};

        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    unique case (i_head.kind)
                        K_WRITE: begin
                            o_pop  = 1'b1;
                            mem_we = 1'b1;
                        end
                        K_PATCOL, K_BITMAP: begin
                            o_pop    = 1'b1;
                            mem_re   = 1'b1;
                            mem_addr = i_head.name_addr;
                            n_state  = S_G1;
                        end
                        K_TILE: begin
                            o_pop    = 1'b1;
                            mem_re   = 1'b1;
                            mem_addr = i_head.name_addr;
                            n_state  = S_T1;
                        end
                        default: begin
                            // blank pixel: result straight away
                            if (out_free) begin
                                o_pop       = 1'b1;
                                n_out_valid = 1'b1;
                                n_color     = '0;
                                n_out_pal   = 1'b0;
                                n_out_pri   = 1'b0;
                            end
                        end
                    endcase
                end
            end
            S_G1: begin
                n_tile   = r_q;
                mem_re   = 1'b1;
                mem_addr = r_job.p_hi | {3'd0, r_q, r_job.py};
                n_state  = S_G2;
            end
            S_G2: begin
                n_bit  = pick_bit(r_q, r_job.px);
                mem_re = 1'b1;
                if (r_job.kind == K_BITMAP) begin
                    mem_addr = r_job.c_hi | {3'd0, r_tile, r_job.py};
                end else begin
                    mem_addr = r_job.c_hi | {9'd0, r_tile[7:3]};
                end
                n_state = S_G3;
            end
            S_G3: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_color     = r_bit ? r_q[7:4] : r_q[3:0];
                    n_out_pal   = 1'b0;
                    n_out_pri   = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            S_T1: begin
                n_lo     = r_q;
                mem_re   = 1'b1;
                mem_addr = r_job.name_addr | {{(RAM_ADDR_BITS-1){1'b0}}, 1'b1};
                n_state  = S_T2;
            end
            S_T2: begin
                // entry: bit 9 horizontal flip, 10 vertical flip, 11 palette, 12 priority
                n_px     = r_job.px ^ {3{entry[9]}};
                n_pal    = entry[11];
                n_pri    = entry[12];
                n_base   = {entry[8:0], py_f, 2'b00};
                mem_re   = 1'b1;
                mem_addr = {entry[8:0], py_f, 2'b00};
                n_state  = S_T3;
            end
            S_T3: begin
                n_c[0]   = pick_bit(r_q, r_px);
                mem_re   = 1'b1;
                mem_addr = r_base | 14'd1;
                n_state  = S_T4;
            end
            S_T4: begin
                n_c[1]   = pick_bit(r_q, r_px);
                mem_re   = 1'b1;
                mem_addr = r_base | 14'd2;
                n_state  = S_T5;
            end
            S_T5: begin
                n_c[2]   = pick_bit(r_q, r_px);
                mem_re   = 1'b1;
                mem_addr = r_base | 14'd3;
                n_state  = S_T6;
            end
            S_T6: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_color     = {pick_bit(r_q, r_px), r_c};
                    n_out_pal   = r_pal;
                    n_out_pri   = r_pri && ({pick_bit(r_q, r_px), r_c} != 4'd0);
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // single-port video RAM, registered read with enable
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= i_head.wr_data;
        end
        if (mem_re) begin
            r_q <= mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_head;
        end
        r_tile    <= n_tile;
        r_lo      <= n_lo;
        r_bit     <= n_bit;
        r_px      <= n_px;
        r_c       <= n_c;
        r_pal     <= n_pal;
        r_pri     <= n_pri;
        r_base    <= n_base;
        r_color   <= n_color;
        r_out_pal <= n_out_pal;
        r_out_pri <= n_out_pri;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_pixel_color    = r_color;
    assign o_palette_select = r_out_pal;
    assign o_priority_flag  = r_out_pri;

endmodule

FILE: sv/tile_background_pixel_fetch.sv
// ----------------------------------------------------------------------------
// tile_background_pixel_fetch
// Video RAM with background pixel generator: a front classifier, a job
// queue and a sequencer that reads the RAM one byte per cycle while not stalled.
// ----------------------------------------------------------------------------
// The back end takes one job at a time: a write or blank item needs no RAM read,
// pattern-and-color and bitmap modes make three RAM reads and tile mode six, all
// through the single video RAM port.
// The input takes items while the queue has room, also during a stalled result.
// Reset (synchronous, active low) clears config registers, queue, sequencer and
// result valid; video RAM is not cleared and is undefined until written.
module tile_background_pixel_fetch import tbpf_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // item input
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_operation,
    input  logic [7:0]               i_pixel_column,
    input  logic [8:0]               i_pixel_line,
    input  logic [RAM_ADDR_BITS-1:0] i_ram_address,
    input  logic [7:0]               i_ram_data,
    // result output
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [3:0]               o_pixel_color,
    output logic                     o_palette_select,
    output logic                     o_priority_flag,
    // register port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [4:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    t_job     front_job;
    t_job     head;
    logic     q_full;
    logic     q_empty;
    logic     q_pop;
    logic     push;

    assign reg_idx = t_reg_idx'(paddr[4:2]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                REG_DISPLAY_MODE: r_cfg.display_mode       <= pwdata[3:0];
                REG_NAME_BASE:    r_cfg.name_table_base    <= pwdata[3:0];
                REG_PATTERN_BASE: r_cfg.pattern_table_base <= pwdata[2:0];
                REG_COLOR_BASE:   r_cfg.color_table_base   <= pwdata[7:0];
                REG_SCROLL_X:     r_cfg.scroll_x           <= pwdata[7:0];
                REG_SCROLL_Y:     r_cfg.scroll_y           <= pwdata[7:0];
                REG_LOCK_TOP:     r_cfg.lock_top_rows      <= pwdata[0];
                REG_LOCK_RIGHT:   r_cfg.lock_right_columns <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_DISPLAY_MODE: prdata = {28'd0, r_cfg.display_mode};
            REG_NAME_BASE:    prdata = {28'd0, r_cfg.name_table_base};
            REG_PATTERN_BASE: prdata = {29'd0, r_cfg.pattern_table_base};
            REG_COLOR_BASE:   prdata = {24'd0, r_cfg.color_table_base};
            REG_SCROLL_X:     prdata = {24'd0, r_cfg.scroll_x};
            REG_SCROLL_Y:     prdata = {24'd0, r_cfg.scroll_y};
            REG_LOCK_TOP:     prdata = {31'd0, r_cfg.lock_top_rows};
            REG_LOCK_RIGHT:   prdata = {31'd0, r_cfg.lock_right_columns};
            default:          prdata = '0;
        endcase
    end

    assign o_in_ready = !q_full;
    assign push       = i_in_valid && !q_full;

    tbpf_front u_front (
        .i_cfg          (r_cfg),
        .i_operation    (i_operation),
        .i_pixel_column (i_pixel_column),
        .i_pixel_line   (i_pixel_line),
        .i_ram_address  (i_ram_address),
        .i_ram_data     (i_ram_data),
        .o_job          (front_job)
    );

    tbpf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (q_pop),
        .o_head  (head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    tbpf_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (head),
        .i_empty          (q_empty),
        .o_pop            (q_pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_pixel_color    (o_pixel_color),
        .o_palette_select (o_palette_select),
        .o_priority_flag  (o_priority_flag)
    );

endmodule

FILE: sv/tbpf_checker.sv
// ----------------------------------------------------------------------------
// tbpf_checker
// Port-level checks of the tile background pixel fetch result channel.
// ----------------------------------------------------------------------------
module tbpf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [3:0] o_pixel_color,
    input logic       o_palette_select,
    input logic       o_priority_flag
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result item dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
        $stable(o_pixel_color) && $stable(o_palette_select) && $stable(o_priority_flag))
        else $error("result item changed while stalled");

    // transparent pixels never carry priority
    a_pri_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_priority_flag |-> o_pixel_color != 4'd0)
        else $error("priority set on transparent pixel");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind tile_background_pixel_fetch tbpf_checker u_tbpf_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_pixel_color    (o_pixel_color),
    .o_palette_select (o_palette_select),
    .o_priority_flag  (o_priority_flag)
);
